### sv/scef_pkg.sv
`default_nettype none

package scef_pkg;

   localparam int KIND_W     = 2;
   localparam int POSITION_W = 12;
   localparam int COLUMN_W   = 11;
   localparam int ROW_W      = 10;
   localparam int OFFSET_W   = 13;
   localparam int VALUE_W    = 64;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int MAX_ENTRIES_DEF = 4096;

   typedef enum logic [KIND_W-1:0] {
      KIND_COL_START = 2'd0,
      KIND_ENTRY     = 2'd1,
      KIND_LOOKUP    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COL_LO,
      ST_COL_HI,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [ROW_W-1:0]   row;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

`default_nettype wire

### sv/scef_if.sv
`default_nettype none

interface scef_req_if;
   import scef_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [KIND_W-1:0]     kind;
   logic [POSITION_W-1:0] position;
   logic [COLUMN_W-1:0]   column;
   logic [ROW_W-1:0]      row;
   logic [OFFSET_W-1:0]   start_offset;
   logic [VALUE_W-1:0]    entry_bits;

   modport source (output valid, kind, position, column, row, start_offset, entry_bits,
                   input ready);
   modport sink   (input valid, kind, position, column, row, start_offset, entry_bits,
                   output ready);
endinterface

interface scef_rsp_if;
   import scef_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] element_bits;
   logic               found;

   modport source (output valid, element_bits, found, input ready);
   modport sink   (input valid, element_bits, found, output ready);
endinterface

`default_nettype wire

### sv/scef_ram.sv
`default_nettype none

module scef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/scef_ctrl.sv
`default_nettype none

module scef_ctrl #(
   parameter int MAX_COLUMNS = scef_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ENTRIES = scef_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   scef_req_if.sink                                  req,
   scef_rsp_if.source                                rsp,
   output logic                                      col_wr_en,
   output logic [$clog2(MAX_COLUMNS+1)-1:0]          col_wr_addr,
   output logic [scef_pkg::OFFSET_W-1:0]             col_wr_data,
   output logic                                      col_rd_en,
   output logic [$clog2(MAX_COLUMNS+1)-1:0]          col_rd_addr,
   input  wire logic [scef_pkg::OFFSET_W-1:0]        col_rd_data,
   output logic                                      ent_wr_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]            ent_wr_addr,
   output scef_pkg::entry_type                       ent_wr_data,
   output logic                                      ent_rd_en,
   output logic [$clog2(MAX_ENTRIES)-1:0]            ent_rd_addr,
   input  wire scef_pkg::entry_type                  ent_rd_data
);
   import scef_pkg::*;

   localparam int CA_W = $clog2(MAX_COLUMNS + 1);
   localparam int EA_W = $clog2(MAX_ENTRIES);
   localparam int SL_W = $clog2(MAX_ENTRIES + 1);

   state_type          state_ff, state_in;
   logic [CA_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SL_W-1:0]    k_ff, k_in;
   logic [SL_W-1:0]    last_ff, last_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;
   logic               res_found_ff, res_found_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_found_ff, rsp_found_in;

   logic [31:0]        col_wide;
   logic [31:0]        col_next_wide;
   logic [31:0]        pos_wide;
   logic [31:0]        bound_wide;
   logic [SL_W-1:0]    bound_slot;
   logic [SL_W-1:0]    k_next;
   logic               rsp_free;

   assign col_wide      = 32'(req.column);
   assign col_next_wide = 32'(col_ff) + 32'd1;
   assign pos_wide      = 32'(req.position);
   assign bound_wide    = (32'(col_rd_data) > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES)
                                                                 : 32'(col_rd_data);
   assign bound_slot    = bound_wide[SL_W-1:0];
   assign k_next        = k_ff + SL_W'(1);
   assign rsp_free      = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      res_value_in = res_value_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      col_wr_en    = 1'b0;
      col_wr_addr  = col_wide[CA_W-1:0];
      col_wr_data  = req.start_offset;
      col_rd_en    = 1'b0;
      col_rd_addr  = col_wide[CA_W-1:0];
      ent_wr_en    = 1'b0;
      ent_wr_addr  = pos_wide[EA_W-1:0];
      ent_wr_data  = '{row: req.row, value: req.entry_bits};
      ent_rd_en    = 1'b0;
      ent_rd_addr  = k_ff[EA_W-1:0];
      req.ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               unique case (kind_type'(req.kind))
                  KIND_COL_START: begin
                     col_wr_en = (col_wide <= 32'(MAX_COLUMNS));
                  end
                  KIND_ENTRY: begin
                     ent_wr_en = (pos_wide < 32'(MAX_ENTRIES));
                  end
                  KIND_LOOKUP: begin
                     row_in       = req.row;
                     col_in       = col_wide[CA_W-1:0];
                     res_value_in = '0;
                     res_found_in = 1'b0;
                     if (col_wide < 32'(MAX_COLUMNS)) begin
                        col_rd_en = 1'b1;
                        state_in  = ST_COL_LO;
                     end else begin
                        state_in  = ST_RESP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COL_LO: begin
            k_in        = bound_slot;
            col_rd_en   = 1'b1;
            col_rd_addr = col_next_wide[CA_W-1:0];
            state_in    = ST_COL_HI;
         end
         ST_COL_HI: begin
            last_in = bound_slot;
            if (k_ff >= bound_slot) begin
               state_in = ST_RESP;
            end else begin
               ent_rd_en = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ent_rd_data.row == row_ff) begin
               res_value_in = ent_rd_data.value;
               res_found_in = 1'b1;
               state_in     = ST_RESP;
            end else if (ent_rd_data.row > row_ff || k_next >= last_ff) begin
               state_in = ST_RESP;
            end else begin
               k_in        = k_next;
               ent_rd_en   = 1'b1;
               ent_rd_addr = k_next[EA_W-1:0];
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff       <= col_in;
      row_ff       <= row_in;
      k_ff         <= k_in;
      last_ff      <= last_in;
      res_value_ff <= res_value_in;
      res_found_ff <= res_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.element_bits = rsp_value_ff;
   assign rsp.found        = rsp_found_ff;

endmodule

`default_nettype wire

### sv/sparse_column_entry_fetch_core.sv
// Sparse matrix element lookup over a compressed-column store. Each request beat either
// writes one column start offset, writes one stored entry (row and 64-bit value), or looks
// up the element at a given row and column; a beat of the unused fourth kind does nothing.
// Only lookups produce a response beat, carrying the stored value with found set, or zero
// with found cleared. A lookup occupies the block until its scan stops at a match, a
// passed row or the column end: the column start memory has one read port and is read
// twice, and the entry memory is read one entry per cycle because each next address
// depends on the previous compare. A lookup of a column out of range skips the memory
// reads and answers with found cleared. A finished response waits in an output register,
// so the next request beat is taken while it is pending. Column starts and entries must be
// loaded before a lookup touches them; the memories are not cleared by reset.

`default_nettype none

module sparse_column_entry_fetch_core #(
   parameter int MAX_COLUMNS = scef_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ENTRIES = scef_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   scef_req_if.sink   req,
   scef_rsp_if.source rsp
);
   import scef_pkg::*;

   localparam int CA_W = $clog2(MAX_COLUMNS + 1);
   localparam int EA_W = $clog2(MAX_ENTRIES);

   logic                col_wr_en;
   logic [CA_W-1:0]     col_wr_addr;
   logic [OFFSET_W-1:0] col_wr_data;
   logic                col_rd_en;
   logic [CA_W-1:0]     col_rd_addr;
   logic [OFFSET_W-1:0] col_rd_data;
   logic                ent_wr_en;
   logic [EA_W-1:0]     ent_wr_addr;
   entry_type           ent_wr_data;
   logic                ent_rd_en;
   logic [EA_W-1:0]     ent_rd_addr;
   entry_type           ent_rd_data;

   scef_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .col_wr_en   (col_wr_en),
      .col_wr_addr (col_wr_addr),
      .col_wr_data (col_wr_data),
      .col_rd_en   (col_rd_en),
      .col_rd_addr (col_rd_addr),
      .col_rd_data (col_rd_data),
      .ent_wr_en   (ent_wr_en),
      .ent_wr_addr (ent_wr_addr),
      .ent_wr_data (ent_wr_data),
      .ent_rd_en   (ent_rd_en),
      .ent_rd_addr (ent_rd_addr),
      .ent_rd_data (ent_rd_data)
   );

   scef_ram #(
      .WIDTH (OFFSET_W),
      .DEPTH (MAX_COLUMNS + 1)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr_en),
      .wr_addr (col_wr_addr),
      .wr_data (col_wr_data),
      .rd_en   (col_rd_en),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   scef_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_ENTRIES)
   ) u_ent_ram (
      .clock   (clock),
      .wr_en   (ent_wr_en),
      .wr_addr (ent_wr_addr),
      .wr_data (ent_wr_data),
      .rd_en   (ent_rd_en),
      .rd_addr (ent_rd_addr),
      .rd_data (ent_rd_data)
   );

endmodule

`default_nettype wire

### verif/sparse_column_entry_fetch_checker.sv
module sparse_column_entry_fetch_checker
#(
   parameter int MAX_COLUMNS = scef_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ENTRIES = scef_pkg::MAX_ENTRIES_DEF
) (
   input  logic clock,
   input  logic reset,
   scef_req_if  req,
   scef_rsp_if  rsp,
   output int   mismatch_count,
   output int   pending_lookups,
   output int   lookup_count,
   output int   found_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import scef_pkg::*;

   typedef struct packed {
      logic [VALUE_W-1:0] element_bits;
      logic               found;
   } element_result_type;

   logic [OFFSET_W-1:0] column_start_tbl [0:MAX_COLUMNS];
   entry_type           entry_tbl [0:MAX_ENTRIES-1];
   element_result_type  expected_elements [$];

   int fails = 0;
   int pending = 0;
   int lookups = 0;
   int hits = 0;

   assign mismatch_count  = fails;
   assign pending_lookups = pending;
   assign lookup_count    = lookups;
   assign found_count     = hits;

   task automatic report_mismatch(string field, logic [VALUE_W-1:0] got,
                                  logic [VALUE_W-1:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $time, field, got, want);
      fails++;
   endtask

   // Entries within a column are scanned in slot order; the scan stops at the
   // first matching row or at the first row above the one sought.
   function automatic element_result_type look_up_element(logic [COLUMN_W-1:0] column,
                                                          logic [ROW_W-1:0] row);
      element_result_type res;
      int unsigned        first;
      int unsigned        last;
      res = '0;
      if (column < MAX_COLUMNS) begin
         first = (column_start_tbl[column] > MAX_ENTRIES) ?
                 MAX_ENTRIES : column_start_tbl[column];
         last  = (column_start_tbl[column + 1] > MAX_ENTRIES) ?
                 MAX_ENTRIES : column_start_tbl[column + 1];
         for (int unsigned k = first; k < last; k++) begin
            if (entry_tbl[k].row == row) begin
               res.element_bits = entry_tbl[k].value;
               res.found = 1'b1;
               break;
            end
            if (entry_tbl[k].row > row) break;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      element_result_type got;
      element_result_type want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got.element_bits = rsp.element_bits;
            got.found = rsp.found;
            if (expected_elements.size() == 0) begin
               report_mismatch("response beat with no lookup pending", got.element_bits, '0);
            end else begin
               want = expected_elements.pop_front();
               if (got.element_bits !== want.element_bits) begin
                  report_mismatch("element_bits", got.element_bits, want.element_bits);
               end
               if (got.found !== want.found) begin
                  report_mismatch("found", VALUE_W'(got.found), VALUE_W'(want.found));
               end
            end
         end
         if (req.valid && req.ready) begin
            case (req.kind)
               KIND_COL_START: begin
                  if (req.column <= MAX_COLUMNS) column_start_tbl[req.column] = req.start_offset;
               end
               KIND_ENTRY: begin
                  if (req.position < MAX_ENTRIES) begin
                     entry_tbl[req.position].row = req.row;
                     entry_tbl[req.position].value = req.entry_bits;
                  end
               end
               KIND_LOOKUP: begin
                  want = look_up_element(req.column, req.row);
                  expected_elements.push_back(want);
                  lookups++;
                  if (want.found) hits++;
               end
               default: ;
            endcase
         end
         pending <= expected_elements.size();
      end
   end

endmodule

### verif/sparse_column_entry_fetch_core_tb.sv
module sparse_column_entry_fetch_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scef_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;

   logic clock;
   logic reset;

   scef_req_if req_bus ();
   scef_rsp_if rsp_bus ();

   int mismatch_count;
   int pending_lookups;
   int lookup_count;
   int found_count;

   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int beat_count     = 0;
   int ignored_count  = 0;
   int recent_column  = 0;

   bit          start_known  [0:MAX_COLUMNS_DEF];
   int unsigned start_shadow [0:MAX_COLUMNS_DEF];
   bit          entry_known  [0:MAX_ENTRIES_DEF-1];

   sparse_column_entry_fetch_core u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   sparse_column_entry_fetch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_bus),
      .rsp             (rsp_bus),
      .mismatch_count  (mismatch_count),
      .pending_lookups (pending_lookups),
      .lookup_count    (lookup_count),
      .found_count     (found_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   function automatic logic [VALUE_W-1:0] random_bits();
      return {$urandom, $urandom};
   endfunction

   // A lookup reads both bounds of its column and may read any entry between them.
   function automatic bit column_readable(logic [COLUMN_W-1:0] column);
      int unsigned first;
      int unsigned last;
      if (column >= MAX_COLUMNS_DEF) return 1'b1;
      if (!start_known[column] || !start_known[column + 1]) return 1'b0;
      first = (start_shadow[column] > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : start_shadow[column];
      last  = (start_shadow[column + 1] > MAX_ENTRIES_DEF) ?
              MAX_ENTRIES_DEF : start_shadow[column + 1];
      for (int unsigned k = first; k < last; k++) begin
         if (!entry_known[k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic send_item(logic [KIND_W-1:0] kind, logic [POSITION_W-1:0] position,
                            logic [COLUMN_W-1:0] column, logic [ROW_W-1:0] row,
                            logic [OFFSET_W-1:0] offset, logic [VALUE_W-1:0] bits);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= kind;
      req_bus.position     <= position;
      req_bus.column       <= column;
      req_bus.row          <= row;
      req_bus.start_offset <= offset;
      req_bus.entry_bits   <= bits;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beat_count++;
      if (kind == KIND_COL_START && column <= MAX_COLUMNS_DEF) begin
         start_known[column] = 1'b1;
         start_shadow[column] = offset;
      end
      if (kind == KIND_ENTRY) entry_known[position] = 1'b1;
      if (kind == KIND_UNUSED) ignored_count++;
   endtask

   task automatic load_column_start(int unsigned column, int unsigned offset);
      send_item(KIND_COL_START, POSITION_W'($urandom_range(0, 4095)), COLUMN_W'(column),
                ROW_W'($urandom_range(0, 1023)), OFFSET_W'(offset), random_bits());
   endtask

   task automatic load_entry(int unsigned position, int unsigned row,
                             logic [VALUE_W-1:0] bits);
      send_item(KIND_ENTRY, POSITION_W'(position), COLUMN_W'($urandom_range(0, 2047)),
                ROW_W'(row), OFFSET_W'($urandom_range(0, 8191)), bits);
   endtask

   // Lookups that would touch a never-written slot are moved out of range.
   task automatic look_up(int unsigned col, int unsigned row);
      logic [COLUMN_W-1:0] column;
      column = COLUMN_W'(col);
      if (!column_readable(column)) begin
         column = COLUMN_W'(MAX_COLUMNS_DEF + $urandom_range(0, 1023));
      end
      send_item(KIND_LOOKUP, POSITION_W'($urandom_range(0, 4095)), column, ROW_W'(row),
                OFFSET_W'($urandom_range(0, 8191)), random_bits());
   endtask

   task automatic send_noise();
      logic [KIND_W-1:0] kind;
      kind = KIND_W'($urandom_range(0, 3));
      if (kind == KIND_LOOKUP) begin
         if ($urandom_range(0, 1) == 0) begin
            look_up($urandom_range(0, 2047), $urandom_range(0, 1023));
         end else begin
            look_up(recent_column + $urandom_range(0, 6), $urandom_range(0, 1023));
         end
      end else begin
         send_item(kind, POSITION_W'($urandom_range(0, 4095)),
                   COLUMN_W'($urandom_range(0, 2047)), ROW_W'($urandom_range(0, 1023)),
                   OFFSET_W'($urandom_range(0, 8191)), random_bits());
      end
   endtask

   // Lays out a few adjacent columns with rising rows (random rows unless sorted_rows is set), then looks them up.
   task automatic build_matrix(bit sorted_rows);
      int ncols;
      int col0;
      int ent0;
      int total;
      int slot;
      int r;
      int lookups;
      int counts [6];
      int ent_col [$];
      int ent_row [$];
      ncols = $urandom_range(1, 6);
      total = 0;
      for (int c = 0; c < ncols; c++) begin
         counts[c] = $urandom_range(0, 5);
         total += counts[c];
      end
      col0 = $urandom_range(0, MAX_COLUMNS_DEF - ncols);
      ent0 = $urandom_range(0, MAX_ENTRIES_DEF - total);
      recent_column = col0;
      slot = ent0;
      for (int c = 0; c <= ncols; c++) begin
         load_column_start(col0 + c, slot);
         if (c < ncols) slot += counts[c];
      end
      for (int c = 0; c < ncols; c++) begin
         r = $urandom_range(0, 200);
         for (int e = 0; e < counts[c]; e++) begin
            ent_col.push_back(col0 + c);
            ent_row.push_back(sorted_rows ? r : $urandom_range(0, 1023));
            r += $urandom_range(1, 200);
         end
      end
      for (int e = 0; e < total; e++) load_entry(ent0 + e, ent_row[e], random_bits());
      lookups = total + ncols + $urandom_range(1, 4);
      for (int n = 0; n < lookups; n++) begin
         if (total != 0 && $urandom_range(0, 99) < 55) begin
            slot = $urandom_range(0, total - 1);
            look_up(ent_col[slot], ent_row[slot] + (($urandom_range(0, 3) == 0) ? 1 : 0));
         end else begin
            look_up(col0 + $urandom_range(0, ncols - 1), $urandom_range(0, 1023));
         end
      end
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups != 0) @(posedge clock);
   endtask

   initial begin
      int base;
      int progress;
      int phase;
      int holds_issued;
      req_bus.valid        <= 1'b0;
      req_bus.kind         <= KIND_COL_START;
      req_bus.position     <= '0;
      req_bus.column       <= '0;
      req_bus.row          <= '0;
      req_bus.start_offset <= '0;
      req_bus.entry_bits   <= '0;
      reset <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      load_column_start(0, 0);
      load_column_start(1, 3);
      load_entry(0, 0, '0);
      load_entry(1, 500, '1);
      load_entry(2, 1023, 64'h8000_0000_0000_0001);
      look_up(0, 0);
      look_up(0, 1023);
      look_up(0, 700);
      look_up(0, 1);
      load_column_start(1023, 4094);
      load_column_start(1024, 8191);
      load_entry(4094, 10, 64'h0123_4567_89ab_cdef);
      load_entry(4095, 20, 64'hfedc_ba98_7654_3210);
      look_up(1023, 20);
      look_up(1023, 1023);
      load_column_start(2, 3);
      look_up(1, 500);
      load_column_start(1022, 5000);
      look_up(1022, 10);
      look_up(1024, 0);
      look_up(2047, 1023);
      send_item(KIND_UNUSED, '0, '0, ROW_W'(500), OFFSET_W'(7), '1);
      look_up(0, 500);
      load_column_start(2047, 0);
      load_column_start(1025, 77);

      base = beat_count - ignored_count;
      phase = -1;
      holds_issued = 0;
      while (beat_count - ignored_count - base < RANDOM_ITEMS) begin
         progress = beat_count - ignored_count - base;
         if (progress * 4 / RANDOM_ITEMS != phase) begin
            wait_for_drain();
            phase = progress * 4 / RANDOM_ITEMS;
            case (phase)
               0: begin
                  send_idle_pct = 0;
                  recv_stall_pct <= 0;
               end
               1: begin
                  send_idle_pct = 80;
                  recv_stall_pct <= 0;
               end
               2: begin
                  send_idle_pct = 0;
                  recv_stall_pct <= 80;
               end
               default: begin
                  send_idle_pct = 33;
                  recv_stall_pct <= 33;
               end
            endcase
         end
         if ((holds_issued == 0 && progress > 100) || (holds_issued == 1 && phase == 3)) begin
            hold_requests <= hold_requests + 1;
            holds_issued++;
         end
         if ($urandom_range(0, 99) < 75) begin
            build_matrix($urandom_range(0, 9) != 0);
         end else begin
            repeat ($urandom_range(1, 6)) send_noise();
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d request beats (%0d of an unused kind), %0d lookups, %0d found.",
               beat_count, ignored_count, lookup_count, found_count);
      $display("Idling went through four phases, with %0d long response hold-offs.",
               holds_issued);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
